@@ src/rsip_pkg.sv @@
// ---------------------------------------------------------------------------
// rsip_pkg
// Shared sizes, operation codes and controller/datapath link types for the
// rotated sorted insert position block.
// ---------------------------------------------------------------------------
`default_nettype none

package rsip_pkg;

	localparam int DEPTH  = 64;                 // stack entries
	localparam int IDX_W  = $clog2(DEPTH);      // entry index
	localparam int CNT_W  = $clog2(DEPTH + 1);  // entry count, holds DEPTH
	localparam int DATA_W = 32;
	localparam int POS_W  = 6;
	localparam int OP_W   = 2;
	localparam int OUT_TDATA_W = 8;

	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND = 2'd1;
	localparam logic [OP_W-1:0] OP_QDESC  = 2'd2;
	localparam logic [OP_W-1:0] OP_QASC   = 2'd3;

	// controller -> datapath
	typedef struct packed {
		logic clear;      // empty the stack
		logic append;     // write value at the bottom
		logic start;      // latch query value and mode, restart scan
		logic query_asc;  // mode for start
		logic issue;      // read entry at scan index, advance
		logic load_out;   // capture result into output register
	} cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic cnt_zero;   // stack empty
		logic last_rd;    // scan index points at the bottom entry
	} sts_t;

endpackage

`default_nettype wire

@@ src/rotated_sorted_insert_position.sv @@
// ---------------------------------------------------------------------------
// rotated_sorted_insert_position
// Stack of signed 32-bit values with clear/append, and queries that return
// the rotation count to the place where a value keeps the circular order.
// ---------------------------------------------------------------------------
//
//  channel   dir  tdata                    tuser
//  s_axis    in   [31:0] value (signed)    [1:0] opcode
//  m_axis    out  [5:0] position, [7:6] 0  [0] error
//
//  Clear and append never stall; the block is ready again the next cycle.
//  A query runs in steps: accept, one stack read per stored entry, a drain
//  state for the last read to land, and a done state to decide. No new
//  operation is taken until the query is done; the stack memory has a single
//  read port, so entries are read one after another. A query on an empty
//  stack skips the reads. arst_n clears the entry count and all control;
//  stack contents are not cleared. A finished result waits in the output
//  register; the next operation is taken while it waits, and a later query
//  holds in its done state until the output register is free.
//
`default_nettype none

module rotated_sorted_insert_position (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output      logic        s_axis_tready,
	input  wire logic [31:0] s_axis_tdata,   // [31:0] value
	input  wire logic [1:0]  s_axis_tuser,   // [1:0] opcode
	output      logic        m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output      logic [7:0]  m_axis_tdata,   // [5:0] position, [7:6] zero
	output      logic        m_axis_tuser    // [0] error
);

	rsip_pkg::cmd_t cmd;
	rsip_pkg::sts_t sts;

	logic [rsip_pkg::POS_W-1:0] position;
	logic                       error;

	// sequencer: handshakes and scan control
	rsip_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.opcode    (s_axis_tuser),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// stack memory, scan accumulators and result register
	rsip_dp u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.in_value     ($signed(s_axis_tdata)),
		.out_position (position),
		.out_error    (error)
	);

	assign m_axis_tdata = {{(rsip_pkg::OUT_TDATA_W - rsip_pkg::POS_W){1'b0}}, position};
	assign m_axis_tuser = error;

endmodule

`default_nettype wire

@@ src/rsip_ram.sv @@
// ---------------------------------------------------------------------------
// rsip_ram
// Generic single-clock RAM, one write port, one read port, registered read.
// ---------------------------------------------------------------------------
`default_nettype none

module rsip_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

@@ src/rsip_ctrl.sv @@
// ---------------------------------------------------------------------------
// rsip_ctrl
// Sequencer: accepts operations, walks the scan, hands results to the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rsip_ctrl (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output      logic                     in_ready,
	input  wire logic [rsip_pkg::OP_W-1:0] opcode,
	output      logic                     out_valid,
	input  wire logic                     out_ready,
	output      rsip_pkg::cmd_t           cmd,
	input  wire rsip_pkg::sts_t           sts
);

	localparam logic [1:0] S_IDLE  = 2'd0;
	localparam logic [1:0] S_SCAN  = 2'd1;
	localparam logic [1:0] S_DRAIN = 2'd2;
	localparam logic [1:0] S_DONE  = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic       xfer;
	logic       is_query;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign xfer      = in_valid && in_ready;
	assign is_query  = opcode inside {rsip_pkg::OP_QDESC, rsip_pkg::OP_QASC};
	assign out_valid = out_valid_q;

	always_comb begin
		cmd           = '0;
		cmd.clear     = xfer && (opcode == rsip_pkg::OP_CLEAR);
		cmd.append    = xfer && (opcode == rsip_pkg::OP_APPEND);
		cmd.start     = xfer && is_query;
		cmd.query_asc = (opcode == rsip_pkg::OP_QASC);
		cmd.issue     = (state_q == S_SCAN);
		cmd.load_out  = (state_q == S_DONE) && (!out_valid_q || out_ready);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (cmd.start) begin
					state_d = sts.cnt_zero ? S_DONE : S_SCAN;
				end
			end
			S_SCAN: begin
				if (sts.last_rd) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				state_d = S_DONE;
			end
			S_DONE: begin
				if (cmd.load_out) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

@@ src/rsip_dp.sv @@
// ---------------------------------------------------------------------------
// rsip_dp
// Datapath: stack memory, entry count, one-entry-per-cycle scan with
// running max/min, bracket search, and the result register.
// ---------------------------------------------------------------------------
`default_nettype none

module rsip_dp (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire rsip_pkg::cmd_t                     cmd,
	output      rsip_pkg::sts_t                     sts,
	input  wire logic signed [rsip_pkg::DATA_W-1:0] in_value,
	output      logic [rsip_pkg::POS_W-1:0]         out_position,
	output      logic                               out_error
);

	localparam int IDX_W  = rsip_pkg::IDX_W;
	localparam int CNT_W  = rsip_pkg::CNT_W;
	localparam int DATA_W = rsip_pkg::DATA_W;
	localparam int POS_W  = rsip_pkg::POS_W;

	logic [CNT_W-1:0]         count_q;
	logic                     full;
	logic [IDX_W-1:0]         rd_idx_q;
	logic [DATA_W-1:0]        rdata;
	logic signed [DATA_W-1:0] d;

	logic                     dv_s1;
	logic [IDX_W-1:0]         idx_s1;

	logic signed [DATA_W-1:0] value_q;
	logic                     asc_q;
	logic signed [DATA_W-1:0] top_q, prev_q, max_q, min_q;
	logic [IDX_W-1:0]         maxi_q, mini_q, hiti_q;
	logic                     hit_q;
	logic                     bracket;

	logic                     in_gap, beyond, res_err;
	logic [IDX_W-1:0]         res_idx;
	logic [POS_W-1:0]         pos_q;
	logic                     err_q;

	assign full = (count_q == CNT_W'(rsip_pkg::DEPTH));

	rsip_ram #(
		.WIDTH(DATA_W),
		.DEPTH(rsip_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (cmd.append && !full),
		.waddr (count_q[IDX_W-1:0]),
		.wdata (in_value),
		.re    (cmd.issue),
		.raddr (rd_idx_q),
		.rdata (rdata)
	);

	assign d = $signed(rdata);

	assign sts.cnt_zero = (count_q == '0);
	assign sts.last_rd  = (CNT_W'(rd_idx_q) == count_q - CNT_W'(1));

	// pair (prev, d) brackets the query value
	assign bracket = asc_q ? (prev_q <= value_q && d >= value_q)
	                       : (prev_q >= value_q && d <= value_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q  <= '0;
			rd_idx_q <= '0;
			dv_s1    <= 1'b0;
			hit_q    <= 1'b0;
		end else begin
			if (cmd.clear) begin
				count_q <= '0;
			end else if (cmd.append && !full) begin
				count_q <= count_q + CNT_W'(1);
			end
			if (cmd.start) begin
				rd_idx_q <= '0;
			end else if (cmd.issue) begin
				rd_idx_q <= rd_idx_q + IDX_W'(1);
			end
			dv_s1 <= cmd.issue;
			if (cmd.start) begin
				hit_q <= 1'b0;
			end else if (dv_s1 && idx_s1 != '0 && !hit_q && bracket) begin
				hit_q <= 1'b1;
			end
		end
	end

	// query latch, scan accumulators and result register, payload only
	always_ff @(posedge clk) begin
		idx_s1 <= rd_idx_q;
		if (cmd.start) begin
			value_q <= in_value;
			asc_q   <= cmd.query_asc;
		end
		if (dv_s1) begin
			prev_q <= d;
			if (idx_s1 == '0) begin
				top_q  <= d;
				max_q  <= d;
				min_q  <= d;
				maxi_q <= '0;
				mini_q <= '0;
			end else begin
				if (d > max_q) begin
					max_q  <= d;
					maxi_q <= idx_s1;
				end
				if (d < min_q) begin
					min_q  <= d;
					mini_q <= idx_s1;
				end
				if (!hit_q && bracket) begin
					hiti_q <= idx_s1;
				end
			end
		end
		if (cmd.load_out) begin
			pos_q <= res_err ? '0 : POS_W'(res_idx);
			err_q <= res_err;
		end
	end

	// decision after the scan; prev_q now holds the bottom entry
	always_comb begin
		in_gap = asc_q ? (value_q < top_q && value_q > prev_q)
		               : (value_q > top_q && value_q < prev_q);
		beyond = (value_q > max_q) || (value_q < min_q);
		res_err = 1'b0;
		res_idx = '0;
		if (sts.cnt_zero) begin
			res_err = 1'b1;
		end else if (in_gap) begin
			res_idx = '0;
		end else if (beyond) begin
			res_idx = asc_q ? mini_q : maxi_q;
		end else if (hit_q) begin
			res_idx = hiti_q;
		end else begin
			res_err = 1'b1;
		end
	end

	assign out_position = pos_q;
	assign out_error    = err_q;

endmodule

`default_nettype wire

@@ src/rsip_chk.sv @@
// ---------------------------------------------------------------------------
// rsip_chk
// Port-level checks for rotated_sorted_insert_position, bound to the top.
// ---------------------------------------------------------------------------
`default_nettype none

module rsip_chk (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tvalid,
	input wire logic        s_axis_tready,
	input wire logic [31:0] s_axis_tdata,
	input wire logic [1:0]  s_axis_tuser,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [7:0]  m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// error result carries a zero position
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 8'd0)
		else $error("error result with nonzero position");

	// a query transfer makes the block busy
	a_query_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
			(s_axis_tuser == rsip_pkg::OP_QDESC || s_axis_tuser == rsip_pkg::OP_QASC)
			|=> !s_axis_tready)
		else $error("ready after query transfer");

	// clear and append never stall the input
	a_op_fast: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready &&
			(s_axis_tuser == rsip_pkg::OP_CLEAR || s_axis_tuser == rsip_pkg::OP_APPEND)
			|=> s_axis_tready)
		else $error("not ready after clear or append");

	// a new result only appears at the end of a busy query
	a_out_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(!s_axis_tready))
		else $error("result without a running query");

endmodule

bind rotated_sorted_insert_position rsip_chk u_chk (.*);

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb - rotated_sorted_insert_position
// Streams clear, append and query operations into the block. A local shadow
// of the value stack predicts the insertion position and error flag of every
// query. Each result transfer is compared with the oldest prediction. Both
// stream sides idle at random, and the result side holds off once for a long
// stretch so that the block stalls its input.
// ---------------------------------------------------------------------------

module tb;

	localparam int VAL_MAX    = 32'h7FFF_FFFF;
	localparam int VAL_MIN    = int'(32'h8000_0000);
	localparam int DRAIN_CYC  = 80;           // longer than a full-stack query
	localparam int HOLD_CYC   = 300;          // long result-side stall
	localparam int RAND_ITEMS = 360;

	typedef struct {
		logic [rsip_pkg::POS_W-1:0] pos;
		logic                       err;
	} slot_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	logic [31:0]       s_axis_tdata;    // [31:0] value
	logic [1:0]        s_axis_tuser;    // [1:0] opcode
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	logic [7:0]        m_axis_tdata;    // [5:0] position, [7:6] zero
	logic              m_axis_tuser;    // [0] error

	// shadow of the block state
	int                shadow_stack [rsip_pkg::DEPTH];
	int unsigned       shadow_count;
	slot_t             expected_slots [$];

	// run control and tallies
	bit                burst;           // no idling on either side
	int                hold_req;
	int                mismatches;
	int                items_sent;
	int                appends_dropped;
	int                slots_checked;
	int                slot_errors_seen;

	rotated_sorted_insert_position uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Hard stop, far beyond the slowest legal run.
	initial begin
		#(10_000_000);
		$display("*** FAILED ***");
		$display("timeout with %0d results outstanding", expected_slots.size());
		$finish;
	end

	// Insertion position for value v in the shadow stack.
	function automatic void predict_slot(input bit asc, input int v,
			output logic [rsip_pkg::POS_W-1:0] pos, output logic err);
		int unsigned mx_i;
		int unsigned mn_i;
		int          top;
		int          bot;
		pos = '0;
		err = 1'b0;
		if (shadow_count == 0) begin
			err = 1'b1;
			return;
		end
		top  = shadow_stack[0];
		bot  = shadow_stack[shadow_count-1];
		mx_i = 0;
		mn_i = 0;
		for (int k = 1; k < shadow_count; k++) begin
			if (shadow_stack[k] > shadow_stack[mx_i]) mx_i = k;
			if (shadow_stack[k] < shadow_stack[mn_i]) mn_i = k;
		end
		// value falls in the wrap gap between bottom and top
		if (asc ? (v < top && v > bot) : (v > top && v < bot))
			return;
		// beyond either extreme: goes next to the max (desc) or min (asc)
		if (v > shadow_stack[mx_i] || v < shadow_stack[mn_i]) begin
			pos = rsip_pkg::POS_W'(asc ? mn_i : mx_i);
			return;
		end
		for (int j = 0; j + 1 < shadow_count; j++) begin
			if (asc ? (shadow_stack[j] <= v && shadow_stack[j+1] >= v)
			        : (shadow_stack[j] >= v && shadow_stack[j+1] <= v)) begin
				pos = rsip_pkg::POS_W'(j + 1);
				return;
			end
		end
		err = 1'b1;   // no bracketing pair
	endfunction

	// Offer one operation, wait for its transfer, update the shadow.
	// tvalid stays high after the transfer; the next call or stream_idle
	// decides what happens to it.
	task automatic push_item(input logic [rsip_pkg::OP_W-1:0] op, input int v);
		int                         gap;
		logic [rsip_pkg::POS_W-1:0] p;
		logic                       e;
		slot_t                      s;
		gap = burst ? 0 : $urandom_range(0, 3);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= v;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		items_sent++;
		case (op)
			rsip_pkg::OP_CLEAR: shadow_count = 0;
			rsip_pkg::OP_APPEND: begin
				if (shadow_count < rsip_pkg::DEPTH) begin
					shadow_stack[shadow_count] = v;
					shadow_count++;
				end else begin
					appends_dropped++;
				end
			end
			default: begin
				predict_slot(op == rsip_pkg::OP_QASC, v, p, e);
				s.pos = p;
				s.err = e;
				expected_slots.push_back(s);
			end
		endcase
	endtask

	task automatic stream_idle();
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic load_stack(input int vals[$]);
		push_item(rsip_pkg::OP_CLEAR, $urandom());
		foreach (vals[i]) push_item(rsip_pkg::OP_APPEND, vals[i]);
	endtask

	// Result side: draws a stall per result, honors a long hold request,
	// and checks every transfer against the oldest prediction.
	initial begin : result_check
		int    rx_wait;
		int    hold_left;
		slot_t s;
		rx_wait   = 0;
		hold_left = 0;
		m_axis_tready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				if (expected_slots.size() == 0) begin
					$error("result transfer with no query outstanding");
					mismatches++;
				end else begin
					s = expected_slots.pop_front();
					slots_checked++;
					if (s.err) slot_errors_seen++;
					if (m_axis_tdata[rsip_pkg::POS_W-1:0] !== s.pos) begin
						$error("position: expected %0d, got %0d", s.pos,
							m_axis_tdata[rsip_pkg::POS_W-1:0]);
						mismatches++;
					end
					if (m_axis_tdata[7:rsip_pkg::POS_W] !== '0) begin
						$error("pad: expected 0, got %0d", m_axis_tdata[7:rsip_pkg::POS_W]);
						mismatches++;
					end
					if (m_axis_tuser !== s.err) begin
						$error("error: expected %0d, got %0d", s.err, m_axis_tuser);
						mismatches++;
					end
				end
				rx_wait = burst ? 0 : $urandom_range(0, 3);
			end
			if (hold_req > 0) begin
				hold_left = hold_req;
				hold_req  = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (rx_wait > 0) begin
				rx_wait--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Queries right out of reset and after a clear hit the empty stack.
	task automatic test_empty_stack();
		push_item(rsip_pkg::OP_QDESC, 0);
		push_item(rsip_pkg::OP_QASC, VAL_MIN);
		push_item(rsip_pkg::OP_CLEAR, VAL_MAX);
		push_item(rsip_pkg::OP_QDESC, VAL_MAX);
	endtask

	// One entry: equal value has no bracket, others go beyond an extreme.
	task automatic test_single_entry();
		load_stack('{5});
		push_item(rsip_pkg::OP_QDESC, 5);
		push_item(rsip_pkg::OP_QASC, 5);
		push_item(rsip_pkg::OP_QDESC, 6);
		push_item(rsip_pkg::OP_QASC, 4);
	endtask

	task automatic test_value_extremes();
		load_stack('{VAL_MAX, VAL_MIN, 0});
		push_item(rsip_pkg::OP_QDESC, VAL_MIN);
		push_item(rsip_pkg::OP_QASC, VAL_MAX);
		push_item(rsip_pkg::OP_QDESC, -1);
		push_item(rsip_pkg::OP_QASC, 1);
	endtask

	// Wrap gap, beyond max/min and inner bracket, both directions.
	task automatic test_rotation();
		load_stack('{30, 20, 10, 50, 40});
		push_item(rsip_pkg::OP_QDESC, 25);
		push_item(rsip_pkg::OP_QDESC, 45);
		push_item(rsip_pkg::OP_QDESC, 60);
		push_item(rsip_pkg::OP_QDESC, 35);
		load_stack('{30, 40, 50, 10, 20});
		push_item(rsip_pkg::OP_QASC, 45);
		push_item(rsip_pkg::OP_QASC, 5);
		push_item(rsip_pkg::OP_QASC, 25);
	endtask

	// Wrong-direction lists find no bracket; runs of equal entries bracket at the first pair.
	task automatic test_no_bracket();
		load_stack('{1, 3, 5});
		push_item(rsip_pkg::OP_QDESC, 5);
		push_item(rsip_pkg::OP_QDESC, 1);
		load_stack('{3, 3, 3});
		push_item(rsip_pkg::OP_QASC, 3);
		push_item(rsip_pkg::OP_QDESC, 3);
	endtask

	// Fill past capacity; extra appends must be dropped. Max sits at the
	// bottom entry so the position field reaches its top value.
	task automatic test_full_stack();
		push_item(rsip_pkg::OP_CLEAR, 0);
		for (int i = 0; i < rsip_pkg::DEPTH + 2; i++)
			push_item(rsip_pkg::OP_APPEND, i * 2 - 60);
		push_item(rsip_pkg::OP_QDESC, VAL_MAX);
		push_item(rsip_pkg::OP_QASC, VAL_MIN);
		push_item(rsip_pkg::OP_QASC, 7);
		push_item(rsip_pkg::OP_QDESC, 7);
	endtask

	// Result side holds off while queries keep coming; the output register
	// fills and the block must stall its input until the hold ends.
	task automatic test_backpressure();
		load_stack('{8, 12, 2, 4});
		hold_req = HOLD_CYC;
		for (int i = 0; i < 8; i++)
			push_item(($urandom_range(0, 1) != 0) ? rsip_pkg::OP_QASC : rsip_pkg::OP_QDESC,
				$urandom_range(0, 14));
	endtask

	// Mostly well-formed rotated sorted lists with queries aimed at their
	// entries and neighbors; the rest is random noise.
	task automatic test_random_mix();
		int         vals[$];
		int         base;
		int         n;
		int         r;
		int         v;
		bit         narrow;
		logic [rsip_pkg::OP_W-1:0] op;
		base = items_sent - appends_dropped;
		while (items_sent - appends_dropped - base < RAND_ITEMS) begin
			burst = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 99) < 15) begin
				repeat ($urandom_range(1, 4)) begin
					op = rsip_pkg::OP_W'($urandom_range(0, 3));
					v  = $urandom_range(0, 1) ? int'($urandom()) : $urandom_range(0, 15) - 8;
					push_item(op, v);
				end
			end else begin
				r = $urandom_range(0, 99);
				n = (r < 80) ? $urandom_range(1, 12)
				  : (r < 95) ? $urandom_range(13, rsip_pkg::DEPTH)
				  : $urandom_range(rsip_pkg::DEPTH + 1, rsip_pkg::DEPTH + 6);
				narrow = ($urandom_range(0, 9) < 3);
				vals.delete();
				repeat (n)
					vals.push_back(narrow ? $urandom_range(0, 15) - 8 : int'($urandom()));
				if ($urandom_range(0, 1)) vals.sort();
				else vals.rsort();
				repeat ($urandom_range(0, n - 1)) vals.push_back(vals.pop_front());
				load_stack(vals);
				repeat ($urandom_range(2, 8)) begin
					v = vals[$urandom_range(0, n - 1)];
					case ($urandom_range(0, 4))
						0: ;
						1: v = v + 1;
						2: v = v - 1;
						3: v = int'($urandom());
						default: v = $urandom_range(0, 1) ? VAL_MAX : VAL_MIN;
					endcase
					push_item($urandom_range(0, 1) ? rsip_pkg::OP_QASC : rsip_pkg::OP_QDESC, v);
				end
			end
		end
		burst = 1'b0;
	endtask

	initial begin
		arst_n        <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tuser  <= rsip_pkg::OP_CLEAR;
		burst            = 1'b0;
		hold_req         = 0;
		mismatches       = 0;
		items_sent       = 0;
		appends_dropped  = 0;
		slots_checked    = 0;
		slot_errors_seen = 0;
		shadow_count     = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_single_entry();
		test_value_extremes();
		test_rotation();
		test_no_bracket();
		test_full_stack();
		test_backpressure();
		test_random_mix();

		stream_idle();
		while (expected_slots.size() != 0) @(posedge clk);
		repeat (DRAIN_CYC) @(posedge clk);

		$display("%0d operations streamed, %0d appends dropped on a full stack;",
			items_sent, appends_dropped);
		$display("%0d query results checked, %0d of them flagged as errors.",
			slots_checked, slot_errors_seen);
		if (mismatches == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule
